FILE: design/rswr_pkg.sv
`timescale 1ns / 1ps

package rswr_pkg;

  // field and state widths
  localparam int IDX_W  = 6;
  localparam int CNT_W  = 7;
  localparam int WORD_W = 64;

  // free-slot search works on groups of this many slots
  localparam int GRP_W   = 8;
  localparam int GRP_CNT_W = 4;
  localparam int GRP_OFF_W = 3;

  // generator rotations and shift
  localparam int ROT_A   = 55;
  localparam int SHIFT_T = 14;
  localparam int ROT_B   = 36;

  // seed reset values
  localparam logic [WORD_W-1:0] SEED_A_RST = 64'd1;
  localparam logic [WORD_W-1:0] SEED_B_RST = 64'd2;

  // register select: paddr[3] picks the 64-bit register
  localparam logic REG_SEED_A = 1'b0;
  localparam logic REG_SEED_B = 1'b1;

  typedef struct packed {
    logic start;
    logic gen_step;
    logic scale;
    logic search;
    logic pick;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last;
  } ctrl_status_t;

  function automatic logic [WORD_W-1:0] rotl64(input logic [WORD_W-1:0] v,
                                                input int k);
    return (v << k) | (v >> (WORD_W - k));
  endfunction

endpackage

FILE: design/rswr_ctrl.sv
`timescale 1ns / 1ps

module rswr_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  rswr_pkg::ctrl_status_t status,
  output rswr_pkg::ctrl_cmd_t    cmd
);
  import rswr_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_STEP   = 3'd1;
  localparam logic [2:0] S_SCALE  = 3'd2;
  localparam logic [2:0] S_SEARCH = 3'd3;
  localparam logic [2:0] S_PICK   = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = S_STEP;
        end
      end
      S_STEP: begin
        cmd.gen_step = 1'b1;
        state_next   = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = S_SEARCH;
      end
      S_SEARCH: begin
        cmd.search = 1'b1;
        state_next = S_PICK;
      end
      S_PICK: begin
        cmd.pick   = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_next = status.last ? S_IDLE : S_STEP;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: design/rswr_dp.sv
`timescale 1ns / 1ps

module rswr_dp #(
  parameter int POOL_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rswr_pkg::ctrl_cmd_t           cmd,
  output rswr_pkg::ctrl_status_t        status,
  input  logic [rswr_pkg::CNT_W-1:0]    pool_size,
  input  logic [rswr_pkg::CNT_W-1:0]    pick_count,
  input  logic                          seed_a_wr,
  input  logic                          seed_b_wr,
  input  logic [rswr_pkg::WORD_W-1:0]   seed_data,
  output logic [rswr_pkg::IDX_W-1:0]    picked_index,
  output logic                          last_pick
);
  import rswr_pkg::*;

  localparam int NGRP    = (POOL_DEPTH + GRP_W - 1) / GRP_W;
  localparam int MASK_W  = NGRP * GRP_W;
  localparam int MASK_IW = $clog2(MASK_W);
  localparam int GRP_IW  = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int PROD_W  = WORD_W + CNT_W;

  logic [WORD_W-1:0]  gen_a;
  logic [WORD_W-1:0]  gen_b;
  logic [WORD_W-1:0]  rnd;
  logic [IDX_W-1:0]   pos;
  logic [CNT_W-1:0]   remaining;
  logic [CNT_W-1:0]   picks_left;
  logic [MASK_W-1:0]  taken;
  logic [GRP_IW-1:0]  grp_sel;
  logic [GRP_OFF_W-1:0] off_sel;

  logic [CNT_W-1:0]   size_c;
  logic [CNT_W-1:0]   picks_c;
  logic [WORD_W-1:0]  t_mix;
  logic [PROD_W-1:0]  prod;
  logic [GRP_IW-1:0]  grp_found;
  logic [GRP_OFF_W-1:0] off_found;
  logic [GRP_OFF_W-1:0] bit_found;
  logic [GRP_W-1:0]   free_grp;
  logic [MASK_IW-1:0] pick_slot;

  // request clamping
  always_comb begin
    if (pool_size == '0) begin
      size_c = CNT_W'(1);
    end else if (pool_size > CNT_W'(POOL_DEPTH)) begin
      size_c = CNT_W'(POOL_DEPTH);
    end else begin
      size_c = pool_size;
    end
    if (pick_count == '0) begin
      picks_c = CNT_W'(1);
    end else if (pick_count > size_c) begin
      picks_c = size_c;
    end else begin
      picks_c = pick_count;
    end
  end

  // generator mix term and scaling product
  assign t_mix = gen_a ^ gen_b;
  assign prod  = PROD_W'(rnd) * PROD_W'(remaining);

  // find the group holding the pos-th free slot
  always_comb begin
    logic [GRP_CNT_W-1:0] cnt;
    logic [IDX_W-1:0]     resid;
    logic                 found;
    grp_found = '0;
    off_found = '0;
    resid     = pos;
    found     = 1'b0;
    for (int g = 0; g < NGRP; g++) begin
      cnt = '0;
      for (int b = 0; b < GRP_W; b++) begin
        cnt = cnt + GRP_CNT_W'(!taken[g*GRP_W + b]);
      end
      if (!found) begin
        if (resid < IDX_W'(cnt)) begin
          found     = 1'b1;
          grp_found = GRP_IW'(g);
          off_found = resid[GRP_OFF_W-1:0];
        end else begin
          resid = resid - IDX_W'(cnt);
        end
      end
    end
  end

  // find the off-th free slot within the chosen group
  always_comb begin
    logic [GRP_OFF_W-1:0] seen;
    logic                 found;
    free_grp  = ~taken[grp_sel*GRP_W +: GRP_W];
    bit_found = '0;
    seen      = '0;
    found     = 1'b0;
    for (int b = 0; b < GRP_W; b++) begin
      if (!found && free_grp[b]) begin
        if (seen == off_sel) begin
          found     = 1'b1;
          bit_found = GRP_OFF_W'(b);
        end else begin
          seen = seen + GRP_OFF_W'(1);
        end
      end
    end
  end

  assign pick_slot = MASK_IW'({grp_sel, bit_found});

  // generator state, loaded by seed writes, else stepped on each gen_step
  always_ff @(posedge clk) begin
    if (rst) begin
      gen_a <= SEED_A_RST;
      gen_b <= SEED_B_RST;
    end else if (seed_a_wr || seed_b_wr) begin
      if (seed_a_wr) begin
        gen_a <= seed_data;
      end
      if (seed_b_wr) begin
        gen_b <= seed_data;
      end
    end else if (cmd.gen_step) begin
      gen_a <= rotl64(gen_a, ROT_A) ^ t_mix ^ (t_mix << SHIFT_T);
      gen_b <= rotl64(t_mix, ROT_B);
    end
  end

  // per-request counters and pick flags
  always_ff @(posedge clk) begin
    if (rst) begin
      remaining  <= '0;
      picks_left <= '0;
      last_pick  <= 1'b0;
    end else if (cmd.start) begin
      remaining  <= size_c;
      picks_left <= picks_c;
      last_pick  <= 1'b0;
    end else if (cmd.pick) begin
      remaining  <= remaining - CNT_W'(1);
      picks_left <= picks_left - CNT_W'(1);
      last_pick  <= (picks_left == CNT_W'(1));
    end
  end

  // taken slots: slots past the pool size start out taken
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      for (int i = 0; i < MASK_W; i++) begin
        taken[i] <= (CNT_W'(i) >= size_c);
      end
    end else if (cmd.pick) begin
      taken[pick_slot] <= 1'b1;
    end
  end

  // datapath payload registers
  always_ff @(posedge clk) begin
    if (cmd.gen_step) begin
      rnd <= gen_a + gen_b;
    end
    if (cmd.scale) begin
      pos <= prod[WORD_W +: IDX_W];
    end
    if (cmd.search) begin
      grp_sel <= grp_found;
      off_sel <= off_found;
    end
    if (cmd.pick) begin
      picked_index <= IDX_W'(pick_slot);
    end
  end

  assign status.last = last_pick;

endmodule

FILE: design/random_sample_without_replacement.sv
`timescale 1ns / 1ps

// channel   signals                               transfer when
// in        in_valid, in_stall, pool_size,        in_valid && !in_stall
//           pick_count
// out       out_valid, out_stall, picked_index,   out_valid && !out_stall
//           last_pick
// cfg       psel, penable, pwrite, paddr, pwdata,  psel && penable && pwrite
//           prdata, pready
//
// a request is accepted in the idle state, then each pick steps through generator
// step, multiply, group search, slot search and output.
// the controller walks one pick at a time; each output waits in its register
// until transferred, and out_stall holds the sequence there.
// rst is synchronous and restores seeds 1 and 2 and the generator.
module random_sample_without_replacement #(
  parameter int POOL_DEPTH = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [rswr_pkg::CNT_W-1:0]  pool_size,
  input  logic [rswr_pkg::CNT_W-1:0]  pick_count,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rswr_pkg::IDX_W-1:0]  picked_index,
  output logic                        last_pick,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [3:0]                  paddr,
  input  logic [rswr_pkg::WORD_W-1:0] pwdata,
  output logic [rswr_pkg::WORD_W-1:0] prdata,
  output logic                        pready
);
  import rswr_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;
  logic [WORD_W-1:0] seed_a;
  logic [WORD_W-1:0] seed_b;
  logic cfg_wr;
  logic seed_a_wr;
  logic seed_b_wr;

  // register write decode
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign seed_a_wr = cfg_wr && (paddr[3] == REG_SEED_A);
  assign seed_b_wr = cfg_wr && (paddr[3] == REG_SEED_B);

  // seed registers for readback
  always_ff @(posedge clk) begin
    if (rst) begin
      seed_a <= SEED_A_RST;
      seed_b <= SEED_B_RST;
    end else begin
      if (seed_a_wr) begin
        seed_a <= pwdata;
      end
      if (seed_b_wr) begin
        seed_b <= pwdata;
      end
    end
  end

  // register read
  always_comb begin
    unique case (paddr[3])
      REG_SEED_A: prdata = seed_a;
      REG_SEED_B: prdata = seed_b;
      default:    prdata = '0;
    endcase
  end

  rswr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  rswr_dp #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .pool_size    (pool_size),
    .pick_count   (pick_count),
    .seed_a_wr    (seed_a_wr),
    .seed_b_wr    (seed_b_wr),
    .seed_data    (pwdata),
    .picked_index (picked_index),
    .last_pick    (last_pick)
  );

endmodule

FILE: sim/random_sample_without_replacement_test.sv
`timescale 1ns / 1ps

module random_sample_without_replacement_test;
  import rswr_pkg::*;

  localparam int POOL_MAX        = 64;
  localparam int SETTLE_CYCLES   = 8;
  localparam int DIR_ROWS        = 19;
  localparam int RANDOM_PHASES   = 3;
  localparam int ITEMS_PER_PHASE = 100;

  // how a directed row is checked: by the deal predictor, or by the typed-in
  // ascending run 0, 1, 2, ... that a zero generator or a first draw gives
  typedef enum logic {ROW_MODEL, ROW_ASCENDING} row_kind_e;

  typedef struct packed {
    logic [1:0]       phase;
    logic [CNT_W-1:0] size;
    logic [CNT_W-1:0] count;
    row_kind_e        kind;
  } stim_row_t;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic             last;
  } draw_t;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [CNT_W-1:0]  pool_size;
  logic [CNT_W-1:0]  pick_count;
  logic              out_valid;
  logic              out_stall;
  logic [IDX_W-1:0]  picked_index;
  logic              last_pick;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [3:0]        paddr;
  logic [WORD_W-1:0] pwdata;
  logic [WORD_W-1:0] prdata;
  logic              pready;

  // expected draws in order, and the draws of the request being dealt
  draw_t             expected_draws[$];
  draw_t             request_draws[$];
  logic [WORD_W-1:0] gen_a;
  logic [WORD_W-1:0] gen_b;
  int                errors;
  logic              quiet;
  int                stall_left;

  // directed rows: reset seeds, then zero seeds, then all-ones seeds
  stim_row_t directed_rows [DIR_ROWS] = '{
    '{2'd0, 7'd64,  7'd1,   ROW_ASCENDING},
    '{2'd0, 7'd1,   7'd1,   ROW_ASCENDING},
    '{2'd0, 7'd0,   7'd0,   ROW_ASCENDING},
    '{2'd0, 7'd0,   7'd127, ROW_ASCENDING},
    '{2'd0, 7'd64,  7'd64,  ROW_MODEL},
    '{2'd0, 7'd127, 7'd0,   ROW_MODEL},
    '{2'd0, 7'd127, 7'd127, ROW_MODEL},
    '{2'd0, 7'd5,   7'd127, ROW_MODEL},
    '{2'd0, 7'd2,   7'd2,   ROW_MODEL},
    '{2'd0, 7'd3,   7'd1,   ROW_MODEL},
    '{2'd0, 7'd63,  7'd62,  ROW_MODEL},
    '{2'd1, 7'd64,  7'd64,  ROW_ASCENDING},
    '{2'd1, 7'd10,  7'd3,   ROW_ASCENDING},
    '{2'd1, 7'd127, 7'd127, ROW_ASCENDING},
    '{2'd1, 7'd7,   7'd0,   ROW_ASCENDING},
    '{2'd2, 7'd64,  7'd64,  ROW_MODEL},
    '{2'd2, 7'd16,  7'd8,   ROW_MODEL},
    '{2'd2, 7'd2,   7'd1,   ROW_MODEL},
    '{2'd2, 7'd1,   7'd0,   ROW_MODEL}
  };

  logic [WORD_W-1:0] phase_seed_a [3] = '{64'd1, 64'd0, {WORD_W{1'b1}}};
  logic [WORD_W-1:0] phase_seed_b [3] = '{64'd2, 64'd0, {WORD_W{1'b1}}};

  random_sample_without_replacement dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .pool_size    (pool_size),
    .pick_count   (pick_count),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .picked_index (picked_index),
    .last_pick    (last_pick),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // effective pool size and pick count after saturation and clamping
  function automatic int clamp_size(input logic [CNT_W-1:0] sz);
    if (sz == 0) return 1;
    if (sz > POOL_MAX) return POOL_MAX;
    return int'(sz);
  endfunction

  function automatic int clamp_picks(input logic [CNT_W-1:0] sz,
                                     input logic [CNT_W-1:0] cnt);
    int n;
    n = clamp_size(sz);
    if (cnt == 0) return 1;
    if (int'(cnt) > n) return n;
    return int'(cnt);
  endfunction

  // deal one request: step the generator per pick, scale to the remaining
  // count by the high part of a 64x7 product, take that slot, close the gap
  function automatic void deal_request(input logic [CNT_W-1:0] sz,
                                       input logic [CNT_W-1:0] cnt);
    logic [IDX_W-1:0]        deck [POOL_MAX];
    logic [WORD_W-1:0]       s0;
    logic [WORD_W-1:0]       s1;
    logic [WORD_W-1:0]       r;
    logic [WORD_W+CNT_W-1:0] prod;
    logic [WORD_W+CNT_W-1:0] wide_n;
    int                      n;
    int                      picks;
    int                      pos;
    request_draws.delete();
    n = clamp_size(sz);
    picks = clamp_picks(sz, cnt);
    for (int i = 0; i < n; i++) deck[i] = IDX_W'(i);
    for (int k = 0; k < picks; k++) begin
      s0 = gen_a;
      s1 = gen_b;
      r = s0 + s1;
      s1 = s1 ^ s0;
      gen_a = ((s0 << ROT_A) | (s0 >> (WORD_W - ROT_A))) ^ s1 ^ (s1 << SHIFT_T);
      gen_b = (s1 << ROT_B) | (s1 >> (WORD_W - ROT_B));
      wide_n = (WORD_W + CNT_W)'(n);
      prod = {{CNT_W{1'b0}}, r} * wide_n;
      pos = int'(prod[WORD_W+CNT_W-1:WORD_W]);
      request_draws.push_back('{deck[pos], (k == picks - 1)});
      for (int i = pos; i + 1 < n; i++) deck[i] = deck[i + 1];
      n--;
    end
  endfunction

  // one request transfer, with an optional idle burst in front
  task automatic issue_request(input logic [CNT_W-1:0] sz,
                               input logic [CNT_W-1:0] cnt,
                               input row_kind_e kind);
    int gap;
    int picks;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    pool_size <= sz;
    pick_count <= cnt;
    do @(posedge clk); while (in_stall);
    deal_request(sz, cnt);
    if (kind == ROW_ASCENDING) begin
      picks = clamp_picks(sz, cnt);
      for (int k = 0; k < picks; k++)
        expected_draws.push_back('{IDX_W'(k), (k == picks - 1)});
    end else begin
      foreach (request_draws[k]) expected_draws.push_back(request_draws[k]);
    end
  endtask

  // drop valid and wait for every expected draw, then let the block settle
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_draws.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write: setup phase, then access phase
  task automatic write_seed(input logic sel, input logic [WORD_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 3'b000};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (sel == REG_SEED_A) gen_a = value;
    else gen_b = value;
  endtask

  task automatic reseed(input logic [WORD_W-1:0] seed_a,
                        input logic [WORD_W-1:0] seed_b);
    wait_drained();
    write_seed(REG_SEED_A, seed_a);
    write_seed(REG_SEED_B, seed_b);
  endtask

  // receiver stall bursts
  always @(negedge clk) begin
    if (stall_left == 0 && !quiet && $urandom_range(0, 7) == 0)
      stall_left = $urandom_range(1, 12);
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // compare each draw transfer with the oldest expectation
  always @(posedge clk) begin
    draw_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_draws.size() == 0) begin
        $display("%0t: unexpected draw: expected none, actual index %0d last %0b",
                 $time, picked_index, last_pick);
        errors++;
      end else begin
        want = expected_draws.pop_front();
        if (picked_index !== want.index) begin
          $display("%0t: picked_index mismatch: expected %0d, actual %0d",
                   $time, want.index, picked_index);
          errors++;
        end
        if (last_pick !== want.last) begin
          $display("%0t: last_pick mismatch: expected %0b, actual %0b",
                   $time, want.last, last_pick);
          errors++;
        end
      end
    end
  end

  // main sequence
  initial begin
    logic [1:0]       phase;
    logic [CNT_W-1:0] sz;
    logic [CNT_W-1:0] cnt;
    int               sel;
    rst = 1'b1;
    in_valid = 1'b0;
    pool_size = '0;
    pick_count = '0;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    quiet = 1'b0;
    errors = 0;
    stall_left = 0;
    gen_a = SEED_A_RST;
    gen_b = SEED_B_RST;
    phase = 2'd0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    for (int row = 0; row < DIR_ROWS; row++) begin
      if (directed_rows[row].phase != phase) begin
        phase = directed_rows[row].phase;
        reseed(phase_seed_a[phase], phase_seed_b[phase]);
      end
      issue_request(directed_rows[row].size, directed_rows[row].count,
                    directed_rows[row].kind);
    end

    // random phases, last one without idling
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      quiet = (p == RANDOM_PHASES - 1);
      if (p == 1) reseed({$urandom, $urandom}, '0);
      else reseed({$urandom, $urandom}, {$urandom, $urandom});
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (p == 0 && i == ITEMS_PER_PHASE / 2) wait_drained();
        // mostly small pools, some full-range ones, a few out-of-range
        sel = $urandom_range(0, 9);
        if (sel < 7) sz = CNT_W'($urandom_range(1, 16));
        else if (sel < 9) sz = CNT_W'($urandom_range(17, POOL_MAX));
        else sz = CNT_W'($urandom_range(0, 127));
        if ($urandom_range(0, 3) == 0) cnt = CNT_W'($urandom_range(0, 127));
        else cnt = CNT_W'($urandom_range(1, clamp_size(sz)));
        issue_request(sz, cnt, ROW_MODEL);
      end
    end

    wait_drained();
    repeat (4 * SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // run limit
  initial begin
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: sim.f
design/rswr_pkg.sv
design/rswr_ctrl.sv
design/rswr_dp.sv
design/random_sample_without_replacement.sv
sim/random_sample_without_replacement_test.sv
